### rtl/nand_page_command_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// nand page command sequencer assertion macros
// shared concurrent assertion forms clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef NAND_PAGE_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define NAND_PAGE_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define NPCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// shared codes, job descriptor and queue status types of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

    localparam int PAGE_BYTES_DEF  = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;

    // input modes
    localparam logic [2:0] M_RESET = 3'd0;
    localparam logic [2:0] M_READ  = 3'd1;
    localparam logic [2:0] M_WRITE = 3'd2;
    localparam logic [2:0] M_ERASE = 3'd3;
    localparam logic [2:0] M_STEP  = 3'd4;

    // operations
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // cycle kinds
    localparam logic [2:0] K_SEL   = 3'd0;
    localparam logic [2:0] K_DESEL = 3'd1;
    localparam logic [2:0] K_CMD   = 3'd2;
    localparam logic [2:0] K_ADDR  = 3'd3;
    localparam logic [2:0] K_WR    = 3'd4;
    localparam logic [2:0] K_RD    = 3'd5;
    localparam logic [2:0] K_WAIT  = 3'd6;

    // command bytes
    localparam logic [7:0] C_READ1   = 8'h00;
    localparam logic [7:0] C_READ2   = 8'h30;
    localparam logic [7:0] C_PROG1   = 8'h80;
    localparam logic [7:0] C_PROG2   = 8'h10;
    localparam logic [7:0] C_ERASE1  = 8'h60;
    localparam logic [7:0] C_ERASE2  = 8'hd0;
    localparam logic [7:0] C_RESET   = 8'hff;

    // job sequences
    localparam logic [1:0] J_RESET = 2'd0;
    localparam logic [1:0] J_ERASE = 2'd1;
    localparam logic [1:0] J_START = 2'd2;
    localparam logic [1:0] J_STEP  = 2'd3;

    typedef struct packed {
        logic [1:0]  seq;
        logic        rd;
        logic        zero_len;
        logic        commit;
        logic        desel;
        logic        setup;
        logic [31:0] addr;
        logic [7:0]  data;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

endpackage

`default_nettype wire

### rtl/npcs_front.sv
// ----------------------------------------------------------------------------
// npcs_front
// accepts items, tracks the transfer state and queues at most one job per item
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_front #(
    parameter int PAGE_BYTES = npcs_pkg::PAGE_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire  [2:0]        i_mode,
    input  wire  [31:0]       i_start_address,
    input  wire  [31:0]       i_length,
    input  wire  [7:0]        i_data_byte,
    input  wire               i_full,
    output logic              o_push,
    output npcs_pkg::t_job    o_job
);
    import npcs_pkg::*;

    localparam int COL_W      = $clog2(PAGE_BYTES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    logic [1:0]       r_op,   n_op;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_left, n_left;
    logic [COL_W-1:0] r_col,  n_col;

    logic        accept;
    logic        page_end;
    logic [31:0] left_m1;
    logic        gen;
    t_job        job;

    assign accept   = i_in_valid && !i_full;
    assign page_end = (r_col == COL_W'(PAGE_BYTES - 1));
    assign left_m1  = r_left - 32'd1;

    always_comb begin
        n_op   = r_op;
        n_addr = r_addr;
        n_left = r_left;
        n_col  = r_col;
        gen    = 1'b0;
        job    = '0;
        case (i_mode)
            M_RESET: begin
                n_op    = OP_IDLE;
                gen     = 1'b1;
                job.seq = J_RESET;
            end
            M_READ, M_WRITE: begin
                gen          = 1'b1;
                job.seq      = J_START;
                job.rd       = (i_mode == M_READ);
                job.zero_len = (i_length == 32'd0);
                job.addr     = i_start_address;
                n_addr       = i_start_address;
                n_left       = i_length;
                n_col        = i_start_address[COL_W-1:0];
                if (i_length == 32'd0) begin
                    n_op = OP_IDLE;
                end else begin
                    n_op = (i_mode == M_READ) ? OP_READ : OP_WRITE;
                end
            end
            M_ERASE: begin
                n_op     = OP_IDLE;
                gen      = 1'b1;
                job.seq  = J_ERASE;
                job.addr = i_start_address >> PAGE_SHIFT;
            end
            M_STEP: begin
                if (r_op != OP_IDLE) begin
                    gen        = 1'b1;
                    job.seq    = J_STEP;
                    job.rd     = (r_op == OP_READ);
                    job.data   = i_data_byte;
                    job.commit = (r_op == OP_WRITE) && (page_end || left_m1 == 32'd0);
                    job.desel  = (left_m1 == 32'd0);
                    job.setup  = page_end && (left_m1 != 32'd0);
                    job.addr   = r_addr + 32'd1;
                    n_addr     = r_addr + 32'd1;
                    n_left     = left_m1;
                    n_col      = page_end ? '0 : r_col + COL_W'(1);
                    if (left_m1 == 32'd0) begin
                        n_op = OP_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_IDLE;
            r_addr <= '0;
            r_left <= '0;
            r_col  <= '0;
        end else if (accept) begin
            r_op   <= n_op;
            r_addr <= n_addr;
            r_left <= n_left;
            r_col  <= n_col;
        end
    end

    assign o_push = accept && gen;
    assign o_job  = job;

endmodule

`default_nettype wire

### rtl/npcs_fifo.sv
// ----------------------------------------------------------------------------
// npcs_fifo
// short job queue between front and back, head read combinationally
// ----------------------------------------------------------------------------
`default_nettype none
`include "nand_page_command_sequencer_top_defines.svh"

module npcs_fifo #(
    parameter int DEPTH = npcs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  npcs_pkg::t_job         i_job,
    input  wire                    i_pop,
    output npcs_pkg::t_job         o_head,
    output npcs_pkg::t_fifo_status o_status
);
    import npcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr,  n_wr;
    logic [PTR_W-1:0] r_rd,  n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_head         = r_mem[r_rd];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `NPCS_ASSERT_NOW(a_push_room, i_push, !o_status.full, "job pushed into full queue")
    `NPCS_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

### rtl/npcs_back.sv
// ----------------------------------------------------------------------------
// npcs_back
// expands queued jobs into nand bus cycles, one result per cycle while not stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "nand_page_command_sequencer_top_defines.svh"

module npcs_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  npcs_pkg::t_job         i_head,
    input  npcs_pkg::t_fifo_status i_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [2:0]             o_cycle_kind,
    output logic [7:0]             o_bus_byte,
    output logic                   o_last
);
    import npcs_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_res;

    function automatic t_res setup_at(input logic rd, input logic [31:0] a,
                                      input logic [3:0] q);
        t_res r;
        case (q)
            4'd0:    r = '{K_CMD, rd ? C_READ1 : C_PROG1};
            4'd1:    r = '{K_ADDR, a[7:0]};
            4'd2:    r = '{K_ADDR, {5'd0, a[10:8]}};
            4'd3:    r = '{K_ADDR, a[18:11]};
            4'd4:    r = '{K_ADDR, a[26:19]};
            4'd5:    r = '{K_ADDR, {3'd0, a[31:27]}};
            4'd6:    r = '{K_CMD, C_READ2};
            default: r = '{K_WAIT, 8'd0};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] job_len(input t_job j);
        logic [3:0] n;
        case (j.seq)
            J_RESET: n = 4'd4;
            J_ERASE: n = 4'd8;
            J_START: n = j.zero_len ? 4'd2 : (j.rd ? 4'd9 : 4'd7);
            default: n = 4'd1 + (j.commit ? 4'd2 : 4'd0) + (j.desel ? 4'd1 : 4'd0)
                         + (j.setup ? (j.rd ? 4'd8 : 4'd6) : 4'd0);
        endcase
        return n;
    endfunction

    function automatic t_res res_at(input t_job j, input logic [3:0] pos);
        t_res       r;
        logic [3:0] q;
        r = '{K_SEL, 8'd0};
        q = pos - 4'd1;
        case (j.seq)
            J_RESET: begin
                case (pos)
                    4'd0:    r = '{K_SEL, 8'd0};
                    4'd1:    r = '{K_CMD, C_RESET};
                    4'd2:    r = '{K_WAIT, 8'd0};
                    default: r = '{K_DESEL, 8'd0};
                endcase
            end
            J_ERASE: begin
                case (pos)
                    4'd0:    r = '{K_SEL, 8'd0};
                    4'd1:    r = '{K_CMD, C_ERASE1};
                    4'd2:    r = '{K_ADDR, j.addr[7:0]};
                    4'd3:    r = '{K_ADDR, j.addr[15:8]};
                    4'd4:    r = '{K_ADDR, j.addr[23:16]};
                    4'd5:    r = '{K_CMD, C_ERASE2};
                    4'd6:    r = '{K_WAIT, 8'd0};
                    default: r = '{K_DESEL, 8'd0};
                endcase
            end
            J_START: begin
                if (pos == 4'd0) begin
                    r = '{K_SEL, 8'd0};
                end else if (j.zero_len) begin
                    r = '{K_DESEL, 8'd0};
                end else begin
                    r = setup_at(j.rd, j.addr, q);
                end
            end
            default: begin
                if (pos == 4'd0) begin
                    r = '{j.rd ? K_RD : K_WR, j.data};
                end else if (j.commit && q == 4'd0) begin
                    r = '{K_CMD, C_PROG2};
                end else if (j.commit && q == 4'd1) begin
                    r = '{K_WAIT, 8'd0};
                end else begin
                    if (j.commit) begin
                        q = q - 4'd2;
                    end
                    if (j.desel) begin
                        r = '{K_DESEL, 8'd0};
                    end else begin
                        r = setup_at(j.rd, j.addr, q);
                    end
                end
            end
        endcase
        return r;
    endfunction

    logic [3:0] r_pos, n_pos;
    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_last;

    logic adv;
    logic take;
    logic res_last;
    t_res res;

    assign adv      = !r_valid || !i_out_stall;
    assign take     = adv && !i_status.empty;
    assign res      = res_at(i_head, r_pos);
    assign res_last = (r_pos == job_len(i_head) - 4'd1);
    assign n_pos    = res_last ? 4'd0 : r_pos + 4'd1;
    assign o_pop    = take && res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
        end else if (adv) begin
            r_valid <= !i_status.empty;
            if (take) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= res.kind;
            r_byte <= res.data;
            r_last <= res_last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_cycle_kind = r_kind;
    assign o_bus_byte   = r_byte;
    assign o_last       = r_last;

    `NPCS_ASSERT_NOW(a_pos_in_job, !i_status.empty, r_pos < job_len(i_head),
        "sequence position past end of job")
    `NPCS_ASSERT_NEXT(a_pos_rewind, take && res_last, r_pos == 4'd0,
        "position not rewound after last result")

endmodule

`default_nettype wire

### rtl/nand_page_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// nand_page_command_sequencer_top
// large-page nand command sequencer: reset, erase, paged read and write
// ----------------------------------------------------------------------------
// The front accepts one input item per clock whenever the job queue has room
// and turns it into at most one job; the back expands the job at the queue
// head into nand bus cycles, one result per clock while the queue holds a job
// and the output is not stalled, behind an output register. Page crossings,
// starts, resets and erases give longer result runs that the QUEUE_DEPTH
// entry queue absorbs. A job is written to the queue memory and its results
// to the output register. PAGE_BYTES must be a power of two.
`default_nettype none

module nand_page_command_sequencer_top #(
    parameter int PAGE_BYTES  = npcs_pkg::PAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH = npcs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_mode,
    input  wire  [31:0] i_start_address,
    input  wire  [31:0] i_length,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_cycle_kind,
    output logic [7:0]  o_bus_byte,
    output logic        o_last
);
    import npcs_pkg::*;

    logic         push;
    logic         pop;
    t_job         job;
    t_job         head;
    t_fifo_status status;

    assign o_in_stall = status.full;

    npcs_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_mode          (i_mode),
        .i_start_address (i_start_address),
        .i_length        (i_length),
        .i_data_byte     (i_data_byte),
        .i_full          (status.full),
        .o_push          (push),
        .o_job           (job)
    );

    npcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    npcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_status     (status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cycle_kind (o_cycle_kind),
        .o_bus_byte   (o_bus_byte),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
